// File: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  // list depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = (CNT_W > 5) ? CNT_W : 5;  // covers count and index ports

  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the captured item to the list
  } ctrl_t;

endpackage

// File: rtl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending list of signed 32-bit values: insert, delete, clear, read.
// ----------------------------------------------------------------------------
//
//  channel   ports                                          handshake
//  -------   ---------------------------------------------  -------------------
//  input     in_operation, in_value, in_index               start & !busy
//  result    out_status, out_read_value, out_count          out_valid, 1 cycle
//
//  Each item is captured first, then compared against every entry in parallel
//  while the row shifts by one place. The result strobes the cycle after,
//  when busy is already low, so a new item can start in the same cycle a
//  result is shown.
//  Reset (synchronous, rst_n low) empties the list; entry contents are left.
//  The receiver cannot stall; out_valid is high for exactly one cycle per item.
//
module sorted_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  // input item
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic signed [31:0]  in_value,
  input  logic [3:0]          in_index,
  // result item
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_read_value,
  output logic [4:0]          out_count
);

  sle_pkg::ctrl_t ctrl;

  // sequencer: load on accept, exec the following cycle, strobe after that
  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  // entry row, compare/shift logic and result registers
  sle_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule

// File: rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: capture an item, execute it, strobe the result.
// ----------------------------------------------------------------------------
module sle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output sle_pkg::ctrl_t  ctrl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   valid_r;

  always_comb begin
    ctrl.load = start && (state_r == S_IDLE);
    ctrl.exec = (state_r == S_EXEC);
    case (state_r)
      S_IDLE:  state_nxt = ctrl.load ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt == S_EXEC);
      valid_r <= ctrl.exec;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

// File: rtl/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath
// Entry row with per-entry compare and one-step shift, plus result registers.
// ----------------------------------------------------------------------------
module sle_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sle_pkg::ctrl_t       ctrl,
  input  logic [1:0]           in_operation,
  input  logic signed [31:0]   in_value,
  input  logic [3:0]           in_index,
  output logic [1:0]           out_status,
  output logic signed [31:0]   out_read_value,
  output logic [4:0]           out_count
);

  // captured item
  sle_pkg::op_t                       op_r;
  logic signed [sle_pkg::VAL_W-1:0]   val_r;
  logic [3:0]                         idx_r;

  // list state
  logic signed [sle_pkg::VAL_W-1:0]   ent_r [sle_pkg::CAPACITY];
  logic [sle_pkg::CNT_W-1:0]          cnt_r;

  // results
  sle_pkg::status_t                   status_r;
  logic signed [sle_pkg::VAL_W-1:0]   rd_r;
  logic [sle_pkg::CNT_W-1:0]          cnt_out_r;

  logic [sle_pkg::CAPACITY-1:0]       live;   // position holds an entry
  logic [sle_pkg::CAPACITY-1:0]       gt;     // insert lands at or below here
  logic [sle_pkg::CAPACITY-1:0]       eq;     // entry matches value
  logic [sle_pkg::CAPACITY-1:0]       hit;    // first match at or below here
  logic signed [sle_pkg::VAL_W-1:0]   ins_ent [sle_pkg::CAPACITY];
  logic signed [sle_pkg::VAL_W-1:0]   del_ent [sle_pkg::CAPACITY];

  logic [sle_pkg::EXT_W-1:0]          idx_ext;
  logic [sle_pkg::EXT_W-1:0]          cnt_ext;
  logic [sle_pkg::EXT_W-1:0]          out_ext;
  logic                               full;
  logic                               found;

  logic [sle_pkg::CNT_W-1:0]          cnt_nxt;
  sle_pkg::status_t                   status_nxt;
  logic signed [sle_pkg::VAL_W-1:0]   rd_nxt;
  logic                               wr_ins;
  logic                               wr_del;

  // per-entry compare
  always_comb begin
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      live[i] = (sle_pkg::CNT_W'(i) < cnt_r);
      gt[i]   = !live[i] || (ent_r[i] > val_r);
      eq[i]   = live[i] && (ent_r[i] == val_r);
    end
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      hit[i] = |(eq & ({sle_pkg::CAPACITY{1'b1}} >> (sle_pkg::CAPACITY - 1 - i)));
    end
  end

  // shifted images of the row for insert and delete
  always_comb begin
    for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
      if (i == 0) begin
        ins_ent[i] = gt[i] ? val_r : ent_r[i];
      end else begin
        ins_ent[i] = gt[i-1] ? ent_r[i-1] : (gt[i] ? val_r : ent_r[i]);
      end
      if (i == sle_pkg::CAPACITY - 1) begin
        del_ent[i] = ent_r[i];
      end else begin
        del_ent[i] = hit[i] ? ent_r[i+1] : ent_r[i];
      end
    end
  end

  assign idx_ext = sle_pkg::EXT_W'(idx_r);
  assign cnt_ext = sle_pkg::EXT_W'(cnt_r);
  assign full    = (cnt_r == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
  assign found   = |eq;

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = sle_pkg::ST_OK;
    rd_nxt     = '0;
    wr_ins     = 1'b0;
    wr_del     = 1'b0;
    case (op_r)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = sle_pkg::ST_FULL;
        end else begin
          wr_ins  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      sle_pkg::OP_DELETE: begin
        if (!found) begin
          status_nxt = sle_pkg::ST_NOT_FOUND;
        end else begin
          wr_del  = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      sle_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      sle_pkg::OP_READ: begin
        if (idx_ext >= cnt_ext) begin
          status_nxt = sle_pkg::ST_BAD_INDEX;
        end else begin
          rd_nxt = ent_r[idx_ext[sle_pkg::IDX_W-1:0]];
        end
      end
      default: begin
        status_nxt = sle_pkg::ST_OK;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r  <= sle_pkg::op_t'(in_operation);
      val_r <= in_value;
      idx_r <= in_index;
    end
  end

  // entry row and results
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < sle_pkg::CAPACITY; i++) begin
        if (wr_ins) begin
          ent_r[i] <= ins_ent[i];
        end else if (wr_del) begin
          ent_r[i] <= del_ent[i];
        end
      end
      status_r  <= status_nxt;
      rd_r      <= rd_nxt;
      cnt_out_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ext        = sle_pkg::EXT_W'(cnt_out_r);
  assign out_status     = status_r;
  assign out_read_value = rd_r;
  assign out_count      = out_ext[4:0];

endmodule

// File: rtl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level timing and result checks for the sorted list engine.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [1:0]          out_status,
  input logic signed [31:0]  out_read_value
);

  // an accepted item makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after accept");

  // the busy cycle is always followed by a result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("no result after busy cycle");

  // every result traces back to an accepted item that went through S_EXEC
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching item");

  // results never strobe in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // only a successful read returns data
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != sle_pkg::ST_OK) |-> (out_read_value == 32'sd0))
    else $error("nonzero read value on failed item");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_read_value (out_read_value)
);
